@@ rtl/core/windowed_retransmit_loss_monitor_assert.svh @@
// Assertion macros used by the loss monitor port checker
`ifndef WINDOWED_RETRANSMIT_LOSS_MONITOR_ASSERT_SVH
`define WINDOWED_RETRANSMIT_LOSS_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define WRLM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("wrlm: assertion failed");

// Next-cycle implication, disabled during reset
`define WRLM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wrlm: assertion failed");

`endif

@@ rtl/core/wrlm_pkg.sv @@
// Shared types and constants of the windowed retransmit loss monitor
package wrlm_pkg;

    localparam int HIST_DEPTH = 5;
    localparam int HIST_IDX_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int HIST_CNT_W = $clog2(HIST_DEPTH + 1);

    localparam int WORD_W    = 32;
    localparam int AGE_W     = 8;
    localparam int PCT_W     = 7;
    localparam int QUOT_BITS = 7;
    localparam int QCNT_W    = $clog2(QUOT_BITS);
    localparam int PROD_W    = WORD_W + QUOT_BITS;

    localparam logic [AGE_W-1:0]  AGE_RESET   = 8'd20;
    localparam logic [PCT_W-1:0]  PCT_MAX     = 7'd100;
    localparam logic [WORD_W-1:0] RTT_INVALID = '1;

    typedef logic [HIST_IDX_W-1:0] hist_idx_t;
    typedef logic [HIST_CNT_W-1:0] hist_cnt_t;

    typedef struct packed {
        logic [WORD_W-1:0] snapshot_time;
        logic [WORD_W-1:0] bytes_sent;
        logic [WORD_W-1:0] bytes_retransmitted;
        logic [WORD_W-1:0] rtt_sample;
    } wrlm_in_t;

    typedef struct packed {
        logic [PCT_W-1:0]  loss_percent;
        logic [WORD_W-1:0] round_trip_ms;
    } wrlm_out_t;

    typedef struct packed {
        logic [WORD_W-1:0] snap_time;
        logic [WORD_W-1:0] sent;
        logic [WORD_W-1:0] retrans;
    } wrlm_entry_t;

    typedef struct packed {
        logic load;
        logic drop;
        logic step;
        logic push;
    } wrlm_hist_cmd_t;

endpackage

@@ rtl/core/windowed_retransmit_loss_monitor.sv @@
// Top level of the windowed retransmit loss monitor
//
//   channel  ports                     direction  payload
//   s_       s_valid/s_ready/s_data    in         wrlm_in_t snapshot
//   m_       m_valid/m_ready/m_data    out        wrlm_out_t loss and round trip
//   cfg_     cfg_we/cfg_wdata          in         max_record_age, no wait
//
// One snapshot is worked on at a time; s_ready is high only while idle.
// Each snapshot drops its stale entries, then runs each remaining entry through the divider
// (skipped when the deltas do not all increase or the result clamps).
// The per-entry work is set by the shared bit-serial divider (one quotient bit a cycle).
// A result waiting in the output register holds the next snapshot's final step only.
// Reset (aresetn low, synchronous) empties the history, zeroes the round trip, age 20.
module windowed_retransmit_loss_monitor
    import wrlm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  wrlm_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output wrlm_out_t        m_data,
    input  logic             cfg_we,
    input  logic [AGE_W-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AGE,
        S_CMP,
        S_WAIT,
        S_OUT
    } mon_state_t;

    mon_state_t        state_reg;
    wrlm_in_t          item_reg;
    logic [AGE_W-1:0]  age_reg;
    logic [PCT_W-1:0]  best_reg;
    hist_cnt_t         idx_reg;
    logic [WORD_W-1:0] rtt_reg;
    logic              m_valid_reg;
    wrlm_out_t         m_data_reg;

    wrlm_hist_cmd_t    hist_cmd;
    wrlm_entry_t       cur_entry;
    wrlm_entry_t       rd_entry;
    hist_cnt_t         hist_count;
    logic              pct_start;
    logic              pct_done;
    logic [PCT_W-1:0]  pct_val;
    logic [WORD_W-1:0] age_gap;
    logic              stale;
    logic              out_free;
    logic              out_load;
    logic [WORD_W-1:0] rtt_next;

    assign cur_entry = '{snap_time: item_reg.snapshot_time,
                         sent:      item_reg.bytes_sent,
                         retrans:   item_reg.bytes_retransmitted};

    // Oldest entry is stale when strictly more than max_record_age behind
    assign age_gap  = item_reg.snapshot_time - rd_entry.snap_time;
    assign stale    = (hist_count != '0) &&
                      (item_reg.snapshot_time >= rd_entry.snap_time) &&
                      (age_gap > WORD_W'(age_reg));
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == S_OUT) && out_free;
    assign rtt_next = (item_reg.rtt_sample != RTT_INVALID) ? item_reg.rtt_sample : rtt_reg;

    // Drive history commands from the sequencer
    always_comb begin
        hist_cmd.load = (state_reg == S_IDLE) && s_valid;
        hist_cmd.drop = (state_reg == S_AGE) && stale;
        hist_cmd.step = (state_reg == S_WAIT) && pct_done;
        hist_cmd.push = out_load;
    end

    assign pct_start = (state_reg == S_CMP) && (idx_reg != hist_count);

    wrlm_hist u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (hist_cmd),
        .wr_entry (cur_entry),
        .rd_entry (rd_entry),
        .count    (hist_count)
    );

    wrlm_pct u_pct (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pct_start),
        .cur     (cur_entry),
        .prev    (rd_entry),
        .done    (pct_done),
        .pct     (pct_val)
    );

    // Sequence: accept, age out, compare each entry, push and present result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            age_reg     <= AGE_RESET;
            rtt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                age_reg <= cfg_wdata;
            end
            // Load a new result, or drop the one just transferred
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        state_reg <= S_AGE;
                    end
                end
                S_AGE: begin
                    if (!stale) begin
                        idx_reg   <= '0;
                        best_reg  <= '0;
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (idx_reg == hist_count) begin
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (pct_done) begin
                        if (pct_val > best_reg) begin
                            best_reg <= pct_val;
                        end
                        idx_reg   <= idx_reg + HIST_CNT_W'(1);
                        state_reg <= S_CMP;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        rtt_reg    <= rtt_next;
                        m_data_reg <= '{loss_percent: best_reg, round_trip_ms: rtt_next};
                        state_reg  <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/core/wrlm_hist.sv @@
// Snapshot history ring with head, tail, read pointer and fill count
module wrlm_hist
    import wrlm_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  wrlm_hist_cmd_t cmd,
    input  wrlm_entry_t    wr_entry,
    output wrlm_entry_t    rd_entry,
    output hist_cnt_t      count
);

    wrlm_entry_t mem_reg [HIST_DEPTH];
    wrlm_entry_t rd_entry_reg;
    hist_idx_t   head_reg, head_next;
    hist_idx_t   tail_reg, tail_next;
    hist_idx_t   ptr_reg,  ptr_next;
    hist_cnt_t   count_reg, count_next;

    function automatic hist_idx_t next_idx(input hist_idx_t idx);
        return (idx == HIST_IDX_W'(HIST_DEPTH - 1)) ? '0 : idx + HIST_IDX_W'(1);
    endfunction

    // Advance pointers; a push into a full ring drops the oldest entry
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        ptr_next   = ptr_reg;
        count_next = count_reg;
        priority if (cmd.push) begin
            tail_next = next_idx(tail_reg);
            if (count_reg == HIST_CNT_W'(HIST_DEPTH)) begin
                head_next = next_idx(head_reg);
            end else begin
                count_next = count_reg + HIST_CNT_W'(1);
            end
        end else if (cmd.drop) begin
            head_next  = next_idx(head_reg);
            ptr_next   = next_idx(ptr_reg);
            count_next = count_reg - HIST_CNT_W'(1);
        end else if (cmd.step) begin
            ptr_next = next_idx(ptr_reg);
        end else if (cmd.load) begin
            ptr_next = head_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            ptr_reg   <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
        end
    end

    // Store the new snapshot at the tail; fetch the entry the read pointer moves to
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem_reg[tail_reg] <= wr_entry;
        end
        rd_entry_reg <= mem_reg[ptr_next];
    end

    assign rd_entry = rd_entry_reg;
    assign count    = count_reg;

endmodule

@@ rtl/core/wrlm_pct.sv @@
// Retransmit percentage of one entry: delta check, times 100, bit-serial divide
module wrlm_pct
    import wrlm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  wrlm_entry_t      cur,
    input  wrlm_entry_t      prev,
    output logic             done,
    output logic [PCT_W-1:0] pct
);

    typedef enum logic [2:0] {
        P_IDLE,
        P_CHECK,
        P_MUL,
        P_DIV,
        P_DONE
    } pct_state_t;

    pct_state_t        state_reg;
    logic              qual_reg;
    logic [WORD_W-1:0] sd_reg;
    logic [WORD_W-1:0] rd_reg;
    logic [PROD_W-1:0] rem_reg;
    logic [PROD_W-1:0] dvs_reg;
    logic [PCT_W-1:0]  quot_reg;
    logic [QCNT_W-1:0] step_reg;
    logic              fits;

    assign fits = (rem_reg >= dvs_reg);

    // Sequence: latch deltas, clamp check, build rd*100, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
        end else begin
            unique case (state_reg)
                P_IDLE: begin
                    if (start) begin
                        qual_reg  <= (cur.snap_time > prev.snap_time) &&
                                     (cur.sent > prev.sent) &&
                                     (cur.retrans > prev.retrans);
                        sd_reg    <= cur.sent - prev.sent;
                        rd_reg    <= cur.retrans - prev.retrans;
                        state_reg <= P_CHECK;
                    end
                end
                P_CHECK: begin
                    if (!qual_reg) begin
                        quot_reg  <= '0;
                        state_reg <= P_DONE;
                    end else if (rd_reg >= sd_reg) begin
                        quot_reg  <= PCT_MAX;
                        state_reg <= P_DONE;
                    end else begin
                        rem_reg   <= PROD_W'({rd_reg, 6'b0}) + PROD_W'({rd_reg, 5'b0});
                        state_reg <= P_MUL;
                    end
                end
                P_MUL: begin
                    rem_reg   <= rem_reg + PROD_W'({rd_reg, 2'b0});
                    dvs_reg   <= PROD_W'({sd_reg, 6'b0});
                    step_reg  <= QCNT_W'(QUOT_BITS - 1);
                    quot_reg  <= '0;
                    state_reg <= P_DIV;
                end
                P_DIV: begin
                    if (fits) begin
                        rem_reg <= rem_reg - dvs_reg;
                    end
                    quot_reg <= {quot_reg[PCT_W-2:0], fits};
                    dvs_reg  <= dvs_reg >> 1;
                    if (step_reg == '0) begin
                        state_reg <= P_DONE;
                    end else begin
                        step_reg <= step_reg - QCNT_W'(1);
                    end
                end
                P_DONE: begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign done = (state_reg == P_DONE);
    assign pct  = quot_reg;

endmodule

@@ rtl/core/wrlm_checker.sv @@
// Port-level checker for the loss monitor and its bind
`include "windowed_retransmit_loss_monitor_assert.svh"

module wrlm_checker
    import wrlm_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input wrlm_out_t m_data
);

    // Loss never exceeds the clamp
    `WRLM_ASSERT_IMP(a_loss_range, aclk, aresetn, m_valid, m_data.loss_percent <= PCT_MAX)
    // Only valid round trip samples are ever reported
    `WRLM_ASSERT_IMP(a_rtt_valid, aclk, aresetn, m_valid, m_data.round_trip_ms != RTT_INVALID)
    // A snapshot transfer closes the input until its work is done
    `WRLM_ASSERT_NXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A stalled result holds
    `WRLM_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

endmodule

bind windowed_retransmit_loss_monitor wrlm_checker u_wrlm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ tb/loss_monitor_checker.sv @@
// Checker that predicts each loss report and compares it with what the monitor returns
module loss_monitor_checker
    import wrlm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  wrlm_in_t         s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  wrlm_out_t        m_data,
    input  logic             cfg_we,
    input  logic [AGE_W-1:0] cfg_wdata,
    output int unsigned      fail_count,
    output int unsigned      pending
);

    // Own copy of the snapshot window, kept as a ring
    wrlm_entry_t       window [HIST_DEPTH];
    hist_idx_t         oldest;
    hist_cnt_t         held;
    logic [AGE_W-1:0]  age_limit;
    logic [WORD_W-1:0] last_rtt;

    wrlm_out_t         expected_reports [$];
    wrlm_out_t         want;

    // Work out the report for one snapshot and advance the window
    function automatic wrlm_out_t predict_report(input wrlm_in_t snap);
        wrlm_entry_t       entry;
        logic [WORD_W-1:0] sent_delta;
        logic [WORD_W-1:0] retx_delta;
        logic [63:0]       ratio;
        logic [PCT_W-1:0]  best;
        wrlm_out_t         report;
        best = '0;

        // Drop stale entries from the oldest end; a later entry stops the scan
        while (held != 0 && snap.snapshot_time >= window[oldest].snap_time &&
               (snap.snapshot_time - window[oldest].snap_time) > age_limit) begin
            oldest = hist_idx_t'((oldest + 1) % HIST_DEPTH);
            held--;
        end

        // Take the largest percentage over entries where all three grew
        for (int i = 0; i < held; i++) begin
            entry = window[hist_idx_t'((oldest + i) % HIST_DEPTH)];
            if (snap.snapshot_time > entry.snap_time && snap.bytes_sent > entry.sent &&
                snap.bytes_retransmitted > entry.retrans) begin
                sent_delta = snap.bytes_sent - entry.sent;
                retx_delta = snap.bytes_retransmitted - entry.retrans;
                ratio = ({32'd0, retx_delta} * 64'd100) / {32'd0, sent_delta};
                if (ratio > 64'(PCT_MAX)) ratio = 64'(PCT_MAX);
                if (ratio[PCT_W-1:0] > best) best = ratio[PCT_W-1:0];
            end
        end

        // Make room when full, then push the new snapshot
        if (held >= HIST_DEPTH) begin
            oldest = hist_idx_t'((oldest + 1) % HIST_DEPTH);
            held--;
        end
        window[hist_idx_t'((oldest + held) % HIST_DEPTH)] = '{snap_time: snap.snapshot_time,
                                                               sent: snap.bytes_sent,
                                                               retrans: snap.bytes_retransmitted};
        held++;

        // Hold the round trip on an invalid sample
        if (snap.rtt_sample != RTT_INVALID) last_rtt = snap.rtt_sample;

        report.loss_percent  = best;
        report.round_trip_ms = last_rtt;
        return report;
    endfunction

    // Track configuration, predict on input transfers, compare on output transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            held       = '0;
            oldest     = '0;
            age_limit  = AGE_RESET;
            last_rtt   = '0;
            fail_count = 0;
            expected_reports.delete();
        end else begin
            if (cfg_we) age_limit = cfg_wdata;
            if (s_valid && s_ready) begin
                expected_reports.insert(expected_reports.size(), predict_report(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t report with none pending: loss %0d, round trip %0d",
                             $time, m_data.loss_percent, m_data.round_trip_ms);
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (m_data.loss_percent !== want.loss_percent) begin
                        $display("%0t loss_percent mismatch: expected %0d, actual %0d",
                                 $time, want.loss_percent, m_data.loss_percent);
                        fail_count++;
                    end
                    if (m_data.round_trip_ms !== want.round_trip_ms) begin
                        $display("%0t round_trip_ms mismatch: expected %0d, actual %0d",
                                 $time, want.round_trip_ms, m_data.round_trip_ms);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_reports.size();
    end

endmodule

@@ tb/tb_top.sv @@
// Top of the loss monitor testbench: clock, reset, snapshot stimulus and verdict
module tb_top;
    import wrlm_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 2000;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    wrlm_in_t          s_data;
    logic              m_valid;
    logic              m_ready = 1'b0;
    wrlm_out_t         m_data;
    logic              cfg_we;
    logic [AGE_W-1:0]  cfg_wdata;

    int unsigned       fail_count;
    int unsigned       pending;

    logic              idle_on = 1'b1;
    logic              hold_go = 1'b0;
    int unsigned       hold_left = 0;
    int unsigned       stall_left = 0;
    int unsigned       quiet_cycles = 0;

    // Running connection counters for well-formed snapshot streams
    logic [WORD_W-1:0] cur_time;
    logic [WORD_W-1:0] cur_sent;
    logic [WORD_W-1:0] cur_retx;
    logic [AGE_W-1:0]  cur_age = AGE_RESET;

    windowed_retransmit_loss_monitor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    loss_monitor_checker report_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            hold_left  <= 0;
            stall_left <= 0;
        end else if (hold_go) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one snapshot, after an optional gap, and hold it until the transfer
    task automatic send_snapshot(input logic [WORD_W-1:0] t, s, r, rtt);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{snapshot_time: t, bytes_sent: s, bytes_retransmitted: r, rtt_sample: rtt};
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every predicted report has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_age(input logic [AGE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_age = value;
    endtask

    // Mostly well-formed counter streams, with jumps, time going back and noise
    task automatic run_traffic(input int unsigned n_items, input bit with_pressure);
        logic [WORD_W-1:0] rtt;
        logic [WORD_W-1:0] sent_step;
        int unsigned       kind;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (with_pressure && i == n_items / 4) wait_drained();
            if (with_pressure && i == n_items / 2) hold_go <= 1'b1;
            if (with_pressure && i == n_items / 2 + 1) hold_go <= 1'b0;

            case ($urandom_range(0, 15))
                0, 1: rtt = RTT_INVALID;
                2: rtt = $urandom;
                default: rtt = $urandom_range(1, 500);
            endcase

            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                case ($urandom_range(0, 3))
                    0: ;
                    1: cur_time += $urandom_range(1, 3);
                    2: cur_time += $urandom_range(0, cur_age / 2 + 1);
                    default: cur_time += $urandom_range(0, cur_age + 3);
                endcase
                sent_step = $urandom_range(0, 4000);
                cur_sent += sent_step;
                case ($urandom_range(0, 4))
                    0: ;
                    1: cur_retx += $urandom_range(0, 3 * sent_step + 10);
                    default: cur_retx += $urandom_range(0, sent_step);
                endcase
                send_snapshot(cur_time, cur_sent, cur_retx, rtt);
            end else if (kind < 88) begin
                // jump the stream anywhere, so the counters also wrap later
                cur_time = $urandom;
                cur_sent = $urandom;
                cur_retx = $urandom;
                send_snapshot(cur_time, cur_sent, cur_retx, rtt);
            end else if (kind < 94) begin
                send_snapshot(cur_time - $urandom_range(1, 40), cur_sent + $urandom_range(0, 4000),
                              cur_retx + $urandom_range(0, 400), rtt);
            end else begin
                send_snapshot($urandom, $urandom, $urandom, rtt);
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset age: empty window, clamp, equal and
        // backward time, age boundary, full window, counter wrap, extremes
        send_snapshot(32'd100, 32'd1000, 32'd10, 32'd0);
        send_snapshot(32'd101, 32'd2000, 32'd510, 32'd50);
        send_snapshot(32'd102, 32'd2100, 32'd710, RTT_INVALID);
        send_snapshot(32'd102, 32'd2200, 32'd720, 32'd7);
        send_snapshot(32'd103, 32'd2200, 32'd800, 32'd8);
        send_snapshot(32'd104, 32'd2300, 32'd800, 32'd9);
        send_snapshot(32'd99, 32'd5000, 32'd900, 32'd10);
        send_snapshot(32'd122, 32'd5100, 32'd950, 32'd11);
        send_snapshot(32'd123, 32'd5200, 32'd1000, 32'd12);
        send_snapshot(32'd200, 32'd5300, 32'd1100, 32'd13);
        send_snapshot(32'd201, 32'hFFFF_FFF0, 32'hFFFF_FF00, 32'hFFFF_FFFE);
        send_snapshot(32'd202, 32'h0000_0010, 32'hFFFF_FFFF, 32'd14);
        send_snapshot(32'd203, 32'h0000_0011, 32'h0000_0005, 32'd15);
        send_snapshot(32'd204, 32'h0000_0012, 32'h0000_0006, 32'd16);
        send_snapshot(32'd205, 32'h0000_0013, 32'hFFFF_FFF0, 32'd17);
        send_snapshot(32'hFFFF_FFF0, 32'h0000_0020, 32'hFFFF_FFF8, RTT_INVALID);
        send_snapshot(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h5555_5555);
        send_snapshot(32'd0, 32'd0, 32'd0, 32'd0);
        wait_drained();

        cur_time = 32'd1000;
        cur_sent = 32'd50000;
        cur_retx = 32'd100;

        // Random phases over several ages, the extremes first
        write_age(8'd0);
        run_traffic(160, 1'b1);
        wait_drained();
        write_age(8'd255);
        run_traffic(160, 1'b0);
        wait_drained();
        write_age(AGE_W'($urandom_range(1, 254)));
        run_traffic(160, 1'b0);
        wait_drained();

        // Last part at full rate on both sides
        idle_on <= 1'b0;
        write_age(AGE_RESET);
        run_traffic(300, 1'b0);
        wait_drained();
        repeat (80) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/wrlm_pkg.sv
rtl/core/wrlm_hist.sv
rtl/core/wrlm_pct.sv
rtl/core/windowed_retransmit_loss_monitor.sv
rtl/core/wrlm_checker.sv
tb/loss_monitor_checker.sv
tb/tb_top.sv
